### hdl/sprite_animation_frame_sequencer_defines.svh
// Assertion macros shared by the sprite animation frame sequencer RTL.
`ifndef SPRITE_ANIMATION_FRAME_SEQUENCER_DEFINES_SVH
`define SPRITE_ANIMATION_FRAME_SEQUENCER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SAFS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SAFS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/safs_pkg.sv
// Package with field widths, register indexes, opcodes and shared types.
`default_nettype none

package safs_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_DIM_W  = 13;
	localparam int RANGE_W    = 16;
	localparam int TIME_W     = 24;
	localparam int ACC_W      = 32;
	localparam int IDX_W      = 16;
	localparam int LEFT_W     = 24;
	localparam int RIGHT_W    = 25;
	localparam int TOP_W      = 28;
	localparam int BOTTOM_W   = 29;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMNS      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_START_FRAME  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_END_FRAME    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_DELAY  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE  = 3'd6;

	localparam logic OP_TICK      = 1'b0;
	localparam logic OP_SET_FRAME = 1'b1;

	typedef struct packed {
		logic busy;
		logic done;
	} safs_div_stat_t;

endpackage

`default_nettype wire

### hdl/safs_divider.sv
// Radix-2 restoring divider that produces one quotient bit per cycle.
`default_nettype none

module safs_divider
	import safs_pkg::*;
#(
	parameter int NUM_W = 16,
	parameter int DEN_W = 13
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [NUM_W-1:0]     num,
	input  wire logic [DEN_W-1:0]     den,
	output safs_div_stat_t            stat,
	output logic      [NUM_W-1:0]     quot,
	output logic      [DEN_W-1:0]     rem
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0]   shifted;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign ge      = shifted >= {1'b0, den_q};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = quo_q;
	assign rem       = rem_q;

endmodule

`default_nettype wire

### hdl/sprite_animation_frame_sequencer.sv
// Top level of the sprite-sheet animation frame sequencer.
//
//   Channel  Handshake            Payload
//   in       in_valid/in_ready    opcode, elapsed_time, new_frame
//   out      out_valid/out_ready  frame_index, finished, rect_left/right/top/bottom
//   cfg      cfg_we               cfg_index, cfg_wdata
//
// A tick that steps the frame runs ST_ACC, ST_SUB and ST_STEP before the divider and both
// multiplies; a tick that adds time without a step skips ST_STEP; a set-frame item or a tick
// on an empty range goes straight to the divider. The block is ready again as the result appears.
// The radix-2 divider for the sheet row and column produces one bit per cycle.
// One item is in work at a time; the next is taken while a result waits in the output register.
// Reset loads the register defaults and clears frame, accumulator and done flag.
`default_nettype none

`include "sprite_animation_frame_sequencer_defines.svh"

module sprite_animation_frame_sequencer
	import safs_pkg::*;
#(
	parameter int FRAME_BITS = 16,
	parameter int DIM_BITS   = 12
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  opcode,
	input  wire logic [TIME_W-1:0]     elapsed_time,
	input  wire logic [IDX_W-1:0]      new_frame,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic      [IDX_W-1:0]      frame_index,
	output logic                       finished,
	output logic      [LEFT_W-1:0]     rect_left,
	output logic      [RIGHT_W-1:0]    rect_right,
	output logic      [TOP_W-1:0]      rect_top,
	output logic      [BOTTOM_W-1:0]   rect_bottom,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int DW    = DIM_BITS + 1;
	localparam int DCW   = (DW > CFG_DIM_W) ? DW : CFG_DIM_W;
	localparam int CW    = (FRAME_BITS > RANGE_W) ? FRAME_BITS : RANGE_W;
	localparam int MW    = BOTTOM_W;
	localparam int QEXT  = (FRAME_BITS > MW) ? FRAME_BITS : MW;
	localparam logic [DCW-1:0] DIM_MAX = DCW'(1) << DIM_BITS;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_ACC   = 4'd1;
	localparam logic [3:0] ST_SUB   = 4'd2;
	localparam logic [3:0] ST_STEP  = 4'd3;
	localparam logic [3:0] ST_DIVGO = 4'd4;
	localparam logic [3:0] ST_DIV   = 4'd5;
	localparam logic [3:0] ST_MUL_L = 4'd6;
	localparam logic [3:0] ST_MUL_T = 4'd7;
	localparam logic [3:0] ST_FIN   = 4'd8;

	logic [CFG_DIM_W-1:0]  frame_width_q;
	logic [CFG_DIM_W-1:0]  frame_height_q;
	logic [CFG_DIM_W-1:0]  columns_q;
	logic [RANGE_W-1:0]    start_frame_q;
	logic [RANGE_W-1:0]    end_frame_q;
	logic [TIME_W-1:0]     frame_delay_q;
	logic                  loop_enable_q;

	logic [3:0]            state_q;
	logic [FRAME_BITS-1:0] frame_q;
	logic [ACC_W-1:0]      acc_q;
	logic                  done_q;
	logic [TIME_W-1:0]     elapsed_q;
	logic [MW-1:0]         prod_q;
	logic [MW-1:0]         left_q;
	logic                  out_valid_q;

	logic [DW-1:0]         cols_eff;
	logic [DW-1:0]         width_eff;
	logic [DW-1:0]         height_eff;
	logic [DCW-1:0]        cols_wide;
	logic [DCW-1:0]        width_wide;
	logic [DCW-1:0]        height_wide;
	logic [DW-1:0]         cols_clamp;

	logic                  accept;
	logic                  div_start;
	safs_div_stat_t        div_stat;
	logic [FRAME_BITS-1:0] div_quot;
	logic [DW-1:0]         div_rem;

	logic [ACC_W:0]        acc_sum;
	logic [FRAME_BITS:0]   next_full;
	logic [CW-1:0]         next_wide;
	logic                  out_of_range;
	logic [QEXT-1:0]       quot_wide;
	logic [MW-1:0]         mul_a;
	logic [DW-1:0]         mul_b;
	logic [CW-1:0]         frame_wide;

	assign cols_wide   = DCW'(columns_q);
	assign width_wide  = DCW'(frame_width_q);
	assign height_wide = DCW'(frame_height_q);
	assign cols_clamp  = (cols_wide > DIM_MAX) ? DIM_MAX[DW-1:0] : cols_wide[DW-1:0];
	assign cols_eff    = (cols_clamp == '0) ? DW'(1) : cols_clamp;
	assign width_eff   = (width_wide > DIM_MAX) ? DIM_MAX[DW-1:0] : width_wide[DW-1:0];
	assign height_eff  = (height_wide > DIM_MAX) ? DIM_MAX[DW-1:0] : height_wide[DW-1:0];

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign div_start = (state_q == ST_DIVGO);

	assign acc_sum      = {1'b0, acc_q} + (ACC_W + 1)'(elapsed_q);
	assign next_full    = {1'b0, frame_q} + (FRAME_BITS + 1)'(1);
	assign next_wide    = CW'(next_full[FRAME_BITS-1:0]);
	assign out_of_range = next_full[FRAME_BITS]
		|| (next_wide < CW'(start_frame_q))
		|| (next_wide > CW'(end_frame_q));

	assign quot_wide  = QEXT'(div_quot);
	assign mul_a      = (state_q == ST_MUL_L) ? MW'(div_rem) : quot_wide[MW-1:0];
	assign mul_b      = (state_q == ST_MUL_L) ? width_eff : height_eff;
	assign frame_wide = CW'(frame_q);

	safs_divider #(
		.NUM_W(FRAME_BITS),
		.DEN_W(DW)
	) u_divider (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (frame_q),
		.den   (cols_eff),
		.stat  (div_stat),
		.quot  (div_quot),
		.rem   (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= CFG_DIM_W'(2);
			frame_height_q <= CFG_DIM_W'(2);
			columns_q      <= CFG_DIM_W'(1);
			start_frame_q  <= '0;
			end_frame_q    <= '0;
			frame_delay_q  <= TIME_W'(65536);
			loop_enable_q  <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata[CFG_DIM_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata[CFG_DIM_W-1:0];
				REG_COLUMNS:      columns_q      <= cfg_wdata[CFG_DIM_W-1:0];
				REG_START_FRAME:  start_frame_q  <= cfg_wdata[RANGE_W-1:0];
				REG_END_FRAME:    end_frame_q    <= cfg_wdata[RANGE_W-1:0];
				REG_FRAME_DELAY:  frame_delay_q  <= cfg_wdata[TIME_W-1:0];
				REG_LOOP_ENABLE:  loop_enable_q  <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			frame_q     <= '0;
			acc_q       <= '0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (opcode == OP_SET_FRAME) begin
							frame_q <= FRAME_BITS'(new_frame);
							done_q  <= 1'b0;
							state_q <= ST_DIVGO;
						end else if (end_frame_q > start_frame_q) begin
							state_q <= ST_ACC;
						end else begin
							state_q <= ST_DIVGO;
						end
					end
				end
				ST_ACC: begin
					acc_q   <= acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
					state_q <= ST_SUB;
				end
				ST_SUB: begin
					if (acc_q > ACC_W'(frame_delay_q)) begin
						acc_q   <= acc_q - ACC_W'(frame_delay_q);
						state_q <= ST_STEP;
					end else begin
						state_q <= ST_DIVGO;
					end
				end
				ST_STEP: begin
					if (!out_of_range) begin
						frame_q <= next_full[FRAME_BITS-1:0];
					end else if (loop_enable_q) begin
						frame_q <= FRAME_BITS'(start_frame_q);
					end else begin
						frame_q <= FRAME_BITS'(end_frame_q);
						done_q  <= 1'b1;
					end
					state_q <= ST_DIVGO;
				end
				ST_DIVGO: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_MUL_L;
					end
				end
				ST_MUL_L: state_q <= ST_MUL_T;
				ST_MUL_T: state_q <= ST_FIN;
				ST_FIN: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			elapsed_q <= elapsed_time;
		end
		if (state_q == ST_MUL_L || state_q == ST_MUL_T) begin
			prod_q <= MW'(mul_a * mul_b);
		end
		if (state_q == ST_MUL_T) begin
			left_q <= prod_q;
		end
		if (state_q == ST_FIN && (!out_valid_q || out_ready)) begin
			frame_index <= frame_wide[IDX_W-1:0];
			finished    <= done_q;
			rect_left   <= left_q[LEFT_W-1:0];
			rect_right  <= left_q[RIGHT_W-1:0] + RIGHT_W'(width_eff);
			rect_top    <= prod_q[TOP_W-1:0];
			rect_bottom <= prod_q + BOTTOM_W'(height_eff);
		end
	end

	assign out_valid = out_valid_q;

	`SAFS_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready, "block ready right after taking an item")
	`SAFS_ASSERT_SAME(a_div_in_div_state, div_stat.busy, state_q == ST_DIV, "divider runs outside its state")
	`SAFS_ASSERT_NEXT(a_fin_waits, (state_q == ST_FIN) && out_valid_q && !out_ready, state_q == ST_FIN, "result dropped while output stalled")

endmodule

`default_nettype wire
